### hdl/lrut_pkg.sv
// Shared constants, field widths and the control store of the LRU timestamp sequencer.
// Used by the channel interfaces and the top level; depends on nothing.
package lrut_pkg;

	localparam int LRUT_NUM_FRAMES  = 256;
	localparam int LRUT_STAMP_WIDTH = 32;

	localparam int OP_W     = 1;
	localparam int FRAME_W  = 8;
	localparam int VICTIM_W = 8;
	localparam int CFG_W    = 9;

	localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

	localparam logic [OP_W-1:0] OP_REF   = 1'b0;
	localparam logic [OP_W-1:0] OP_EVICT = 1'b1;

	localparam int STEP_W = 2;
	localparam logic [STEP_W-1:0] STEP_CLEAR = 2'd0;
	localparam logic [STEP_W-1:0] STEP_IDLE  = 2'd1;
	localparam logic [STEP_W-1:0] STEP_SCAN  = 2'd2;
	localparam logic [STEP_W-1:0] STEP_DONE  = 2'd3;

	localparam int COND_W = 2;
	localparam logic [COND_W-1:0] COND_CLR_LAST  = 2'd0;
	localparam logic [COND_W-1:0] COND_EVICT     = 2'd1;
	localparam logic [COND_W-1:0] COND_SCAN_DONE = 2'd2;
	localparam logic [COND_W-1:0] COND_OUT_FREE  = 2'd3;

	typedef struct packed {
		logic              in_ready;
		logic              clear_wr;
		logic              scan_run;
		logic              out_load;
		logic [COND_W-1:0] cond;
		logic [STEP_W-1:0] target;
	} ctrl_t;

	// One control word per step; the step holds until its condition is met.
	function automatic ctrl_t lrut_ucode(input logic [STEP_W-1:0] step);
		ctrl_t c;
		c = '0;
		unique case (step)
			STEP_CLEAR: begin
				c.clear_wr = 1'b1;
				c.cond     = COND_CLR_LAST;
				c.target   = STEP_IDLE;
			end
			STEP_IDLE: begin
				c.in_ready = 1'b1;
				c.cond     = COND_EVICT;
				c.target   = STEP_SCAN;
			end
			STEP_SCAN: begin
				c.scan_run = 1'b1;
				c.cond     = COND_SCAN_DONE;
				c.target   = STEP_DONE;
			end
			STEP_DONE: begin
				c.out_load = 1'b1;
				c.cond     = COND_OUT_FREE;
				c.target   = STEP_IDLE;
			end
		endcase
		return c;
	endfunction

endpackage

### hdl/lrut_req_if.sv
// Request channel: one word carries an operation code and a frame index.
// Depends on lrut_pkg for the field widths.
interface lrut_req_if import lrut_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OP_W-1:0]     op;
	logic [FRAME_W-1:0]  frame_index;

	modport source (output valid, output op, output frame_index, input ready);
	modport sink   (input valid, input op, input frame_index, output ready);
endinterface

### hdl/lrut_rsp_if.sv
// Response channel: one word carries the chosen victim frame.
// Depends on lrut_pkg for the field width.
interface lrut_rsp_if import lrut_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [VICTIM_W-1:0] victim_frame;

	modport source (output valid, output victim_frame, input ready);
	modport sink   (input valid, input victim_frame, output ready);
endinterface

### hdl/lru_timestamp_replacement.sv
// Exact LRU victim selection with per-frame timestamps, run by a four-step control store.
// One reference may be accepted every cycle while idle.
// An eviction keeps the request channel not ready for min(frames_in_use, NUM_FRAMES) stamp
// reads, one per frame, a drain of the read register and a result step, and shows its victim
// right after them; a victim still held on the response channel lengthens the result step.
// After reset a clearing pass zeroes all NUM_FRAMES stamps, one per cycle, with the request
// channel not ready; configuration writes are taken throughout.
module lru_timestamp_replacement import lrut_pkg::*; #(
	parameter int NUM_FRAMES  = LRUT_NUM_FRAMES,
	parameter int STAMP_WIDTH = LRUT_STAMP_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	lrut_req_if.sink         req,
	lrut_rsp_if.source       rsp,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata
);

	localparam int AW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CW = $clog2(NUM_FRAMES + 1);
	localparam int LW = (CW > CFG_W) ? CW : CFG_W;
	localparam int IW = (CW > FRAME_W) ? CW : FRAME_W;

	logic [STAMP_WIDTH-1:0] stamp_mem [NUM_FRAMES];

	logic [STEP_W-1:0]      step_q;
	logic [AW-1:0]          clr_cnt_q;
	logic [CFG_W-1:0]       frames_q;
	logic [STAMP_WIDTH-1:0] counter_q;
	logic [CW-1:0]          issue_q;
	logic                   rd_valid_s1;
	logic [AW-1:0]          rd_idx_s1;
	logic [STAMP_WIDTH-1:0] rd_data_s1;
	logic                   best_valid_q;
	logic [AW-1:0]          best_idx_q;
	logic [STAMP_WIDTH-1:0] best_stamp_q;
	logic                   out_valid_q;
	logic [VICTIM_W-1:0]    victim_q;

	ctrl_t                  ctrl;
	logic [LW-1:0]          limit;
	logic                   idx_ok;
	logic                   req_acc;
	logic                   ref_acc;
	logic                   evict_acc;
	logic                   issue_en;
	logic                   out_free;
	logic                   cond_hit;
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [STAMP_WIDTH-1:0] mem_wdata;

	always_comb begin
		ctrl = lrut_ucode(step_q);
	end

	assign limit = (LW'(frames_q) > LW'(NUM_FRAMES)) ? LW'(NUM_FRAMES) : LW'(frames_q);

	assign idx_ok    = IW'(req.frame_index) < IW'(NUM_FRAMES);
	assign req.ready = ctrl.in_ready;
	assign req_acc   = req.valid && req.ready;
	assign ref_acc   = req_acc && (req.op == OP_REF) && idx_ok;
	assign evict_acc = req_acc && (req.op == OP_EVICT);
	assign issue_en  = ctrl.scan_run && (LW'(issue_q) < limit);
	assign out_free  = !out_valid_q || rsp.ready;

	always_comb begin
		unique case (ctrl.cond)
			COND_CLR_LAST:  cond_hit = (clr_cnt_q == AW'(NUM_FRAMES - 1));
			COND_EVICT:     cond_hit = evict_acc;
			COND_SCAN_DONE: cond_hit = !issue_en && !rd_valid_s1;
			COND_OUT_FREE:  cond_hit = out_free;
		endcase
	end

	assign mem_we    = ctrl.clear_wr || ref_acc;
	assign mem_waddr = ctrl.clear_wr ? clr_cnt_q : AW'(req.frame_index);
	assign mem_wdata = ctrl.clear_wr ? '0 : counter_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			stamp_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_s1 <= stamp_mem[issue_q[AW-1:0]];
		rd_idx_s1  <= issue_q[AW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q       <= STEP_CLEAR;
			clr_cnt_q    <= '0;
			frames_q     <= CFG_RESET;
			counter_q    <= '0;
			issue_q      <= '0;
			rd_valid_s1  <= 1'b0;
			best_valid_q <= 1'b0;
			best_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cond_hit) begin
				step_q <= ctrl.target;
			end
			if (cfg_we) begin
				frames_q <= cfg_wdata;
			end
			if (ctrl.clear_wr) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (ref_acc) begin
				counter_q <= counter_q + STAMP_WIDTH'(1);
			end
			if (evict_acc) begin
				issue_q      <= '0;
				best_valid_q <= 1'b0;
				best_idx_q   <= '0;
			end else if (issue_en) begin
				issue_q <= issue_q + CW'(1);
			end
			rd_valid_s1 <= issue_en;
			if (rd_valid_s1 && (!best_valid_q || (rd_data_s1 < best_stamp_q))) begin
				best_valid_q <= 1'b1;
				best_idx_q   <= rd_idx_s1;
			end
			if (ctrl.out_load && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && (!best_valid_q || (rd_data_s1 < best_stamp_q))) begin
			best_stamp_q <= rd_data_s1;
		end
		if (ctrl.out_load && out_free) begin
			victim_q <= VICTIM_W'(best_idx_q);
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.victim_frame = victim_q;

`ifndef SYNTHESIS
	a_counter_moves_on_ref: assert property (@(posedge clk) disable iff (!arst_n)
		(counter_q != $past(counter_q)) |-> $past(ref_acc))
		else $error("access counter changed without an accepted reference");

	a_read_only_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid_s1 |-> (step_q == STEP_SCAN))
		else $error("stamp read in flight outside the scan step");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		((step_q == STEP_DONE) && out_free) |=> (rsp.valid && (step_q == STEP_IDLE)))
		else $error("result step did not present a victim");

	a_victim_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q == STEP_DONE) |-> ((limit == '0) || (LW'(best_idx_q) < limit)))
		else $error("victim index outside the frames in use");
`endif

endmodule
